// ===== rtl/lst_pkg.sv =====
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the latency statistics table.
// ----------------------------------------------------------------------------
package lst_pkg;

   localparam int SLOTS      = 32;
   localparam int KEY_BITS   = 16;
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USED_BITS  = $clog2(SLOTS + 1);
   localparam int STAMP_BITS = 48;
   localparam int COUNT_BITS = 32;
   localparam int EXT_BITS   = 32;

   // request field widths
   localparam int KIND_W   = 2;
   localparam int KEYF_W   = 16;
   localparam int SLOTF_W  = 5;
   // response field widths
   localparam int STATUS_W = 3;
   localparam int USEDF_W  = 6;
   localparam int MINF_W   = 33;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [KIND_W-1:0] KIND_SINCE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ONCE  = 2'd1;

   localparam logic CSR_IDX_ENABLED = 1'b0;
   localparam logic CSR_IDX_BASE    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_RECORDED = 3'd0,
      ST_FULL     = 3'd1,
      ST_SKIPPED  = 3'd2,
      ST_DISABLED = 3'd3,
      ST_READ     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_DISABLED,
      OP_FULL,
      OP_RECORD
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
      logic [STAMP_BITS-1:0] sum;
      logic [EXT_BITS-1:0]   min;
      logic [EXT_BITS-1:0]   max;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

// ===== rtl/lst_req_if.sv =====
// ----------------------------------------------------------------------------
// lst_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface lst_req_if;
   import lst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [KEYF_W-1:0]     key;
   logic [STAMP_BITS-1:0] start_us;
   logic [STAMP_BITS-1:0] now_us;
   logic [SLOTF_W-1:0]    slot;

   modport source (output valid, kind, key, start_us, now_us, slot, input ready);
   modport sink (input valid, kind, key, start_us, now_us, slot, output ready);
   modport monitor (input valid, ready, kind, key, start_us, now_us, slot);
endinterface

// ===== rtl/lst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lst_rsp_if
// Response channel: valid/ready handshake with the slot statistics.
// ----------------------------------------------------------------------------
interface lst_rsp_if;
   import lst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [SLOTF_W-1:0]       slot_index;
   logic                     slot_valid;
   logic [KEYF_W-1:0]        slot_key;
   logic [COUNT_BITS-1:0]    sample_count;
   logic [STAMP_BITS-1:0]    sum_us;
   logic signed [MINF_W-1:0] min_us;
   logic [EXT_BITS-1:0]      max_us;
   logic [USEDF_W-1:0]       slots_used;

   modport source (output valid, status, slot_index, slot_valid, slot_key, sample_count,
                   sum_us, min_us, max_us, slots_used, input ready);
   modport sink (input valid, status, slot_index, slot_valid, slot_key, sample_count,
                 sum_us, min_us, max_us, slots_used, output ready);
   modport monitor (input valid, ready, status, slot_index, slot_valid, slot_key,
                    sample_count, sum_us, min_us, max_us, slots_used);
endinterface

// ===== rtl/latency_statistics_table_top.sv =====
// ----------------------------------------------------------------------------
// latency_statistics_table_top
// Per-key latency statistics: key match, slot allocation and saturating
// count/sum/min/max kept in a statistics RAM.
// ----------------------------------------------------------------------------
// one request at a time: a new request is taken only in the idle state; the
//   read-modify-write of the statistics RAM has match and read in the request
//   cycle and the write in the update state, which waits on a stalled response
// reset: synchronous; clears the slot count, enabled, base_us and the fsm;
//   table contents are not cleared and are initialized on slot allocation
module latency_statistics_table_top (
   input  logic                               clock,
   input  logic                               reset,
   lst_req_if.sink                            req_bus,
   lst_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lst_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lst_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lst_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import lst_pkg::*;

   // control state
   state_type            state_ff, state_in;
   logic [USED_BITS-1:0] used_ff, used_in;
   logic                 enabled_ff, enabled_in;
   logic [STAMP_BITS-1:0] base_ff, base_in;

   // key match array
   logic [KEY_BITS-1:0]  keys_ff [SLOTS];

   // request held for the update cycle
   op_type               op_ff, op_in;
   logic                 alloc_ff, alloc_in;
   logic                 once_ff, once_in;
   logic                 read_ok_ff, read_ok_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOTF_W-1:0]   req_slot_ff, req_slot_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [STAMP_BITS-1:0] iv_ff, iv_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLOTF_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                     rsp_svalid_ff, rsp_svalid_in;
   logic [KEYF_W-1:0]        rsp_key_ff, rsp_key_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic [STAMP_BITS-1:0]    rsp_sum_ff, rsp_sum_in;
   logic signed [MINF_W-1:0] rsp_min_ff, rsp_min_in;
   logic [EXT_BITS-1:0]      rsp_max_ff, rsp_max_in;
   logic [USEDF_W-1:0]       rsp_used_ff, rsp_used_in;

   logic accept, fire, csr_write;
   logic is_read, hit, full;
   logic [SLOT_BITS-1:0] hit_idx;
   logic [STAMP_BITS-1:0] from_us;

   logic [SLOT_BITS-1:0] ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;
   logic                 ram_wr_en;
   entry_type            old_entry, new_entry, shown;
   logic [EXT_BITS-1:0]  iv32;
   logic [STAMP_BITS:0]  sum_wide;
   logic                 skip, recorded, show_valid;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      enabled_in = enabled_ff;
      base_in    = base_ff;
      if (csr_write) begin
         unique case (csr_paddr[CSR_ADDR_BITS-1])
            CSR_IDX_ENABLED: enabled_in = csr_pwdata[0];
            CSR_IDX_BASE:    base_in    = csr_pwdata[STAMP_BITS-1:0];
            default:         ;
         endcase
      end
      unique case (csr_paddr[CSR_ADDR_BITS-1])
         CSR_IDX_ENABLED: csr_prdata = CSR_DATA_BITS'(enabled_ff);
         CSR_IDX_BASE:    csr_prdata = CSR_DATA_BITS'(base_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- request cycle: match and decode ----------------
   assign accept  = req_bus.valid && req_bus.ready;
   assign is_read = req_bus.kind[1];
   assign key_in  = KEY_BITS'(req_bus.key);
   assign full    = (used_ff == USED_BITS'(SLOTS));

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if ((USED_BITS'(i) < used_ff) && (keys_ff[i] == key_in)) begin
            hit     = 1'b1;
            hit_idx = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      priority if (is_read) begin
         op_in = OP_READ;
      end else if (!enabled_ff) begin
         op_in = OP_DISABLED;
      end else if (!hit && full) begin
         op_in = OP_FULL;
      end else begin
         op_in = OP_RECORD;
      end
      alloc_in    = (op_in == OP_RECORD) && !hit;
      once_in     = (req_bus.kind == KIND_ONCE);
      read_ok_in  = (req_bus.slot < used_ff) && (req_bus.slot < SLOTS);
      req_slot_in = req_bus.slot;
      if (is_read) begin
         slot_in = SLOT_BITS'(req_bus.slot);
      end else if (hit) begin
         slot_in = hit_idx;
      end else begin
         slot_in = SLOT_BITS'(used_ff);
      end
      from_us = once_in ? base_ff : req_bus.start_us;
      iv_in   = (req_bus.now_us > from_us) ? (req_bus.now_us - from_us) : '0;
      used_in = (accept && alloc_in) ? used_ff + 1'b1 : used_ff;
   end

   // hold the address during the update so the read data stays put
   assign ram_rd_addr = (state_ff == S_IDLE) ? slot_in : slot_ff;

   // ---------------- update cycle: read-modify-write ----------------
   always_comb begin
      old_entry = alloc_ff ? '0 : entry_type'(ram_rd_data);
      iv32      = (|iv_ff[STAMP_BITS-1:EXT_BITS]) ? '1 : iv_ff[EXT_BITS-1:0];
      sum_wide  = {1'b0, old_entry.sum} + {1'b0, iv_ff};

      new_entry.key   = key_ff;
      new_entry.count = (&old_entry.count) ? old_entry.count : old_entry.count + 1'b1;
      new_entry.sum   = sum_wide[STAMP_BITS] ? '1 : sum_wide[STAMP_BITS-1:0];
      new_entry.min   = ((old_entry.count == '0) || (iv32 < old_entry.min)) ?
                        iv32 : old_entry.min;
      new_entry.max   = (iv32 > old_entry.max) ? iv32 : old_entry.max;

      skip     = once_ff && (old_entry.count != '0);
      recorded = (op_ff == OP_RECORD) && !skip;
      shown    = recorded ? new_entry : old_entry;
   end

   assign ram_wr_en = fire && recorded;

   lst_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOTS)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- response build ----------------
   always_comb begin
      unique case (op_ff)
         OP_READ: begin
            rsp_status_in = ST_READ;
            show_valid    = read_ok_ff;
            rsp_index_in  = req_slot_ff;
         end
         OP_DISABLED: begin
            rsp_status_in = ST_DISABLED;
            show_valid    = 1'b0;
            rsp_index_in  = '0;
         end
         OP_FULL: begin
            rsp_status_in = ST_FULL;
            show_valid    = 1'b0;
            rsp_index_in  = '0;
         end
         OP_RECORD: begin
            rsp_status_in = skip ? ST_SKIPPED : ST_RECORDED;
            show_valid    = 1'b1;
            rsp_index_in  = SLOTF_W'(slot_ff);
         end
         default: begin
            rsp_status_in = ST_READ;
            show_valid    = 1'b0;
            rsp_index_in  = '0;
         end
      endcase
      rsp_svalid_in = show_valid;
      rsp_used_in   = USEDF_W'(used_ff);
      if (show_valid) begin
         rsp_key_in   = KEYF_W'(shown.key);
         rsp_count_in = shown.count;
         rsp_sum_in   = shown.sum;
         rsp_max_in   = shown.max;
         // no sample yet reads as minus one
         rsp_min_in   = (shown.count != '0) ? $signed({1'b0, shown.min}) : '1;
      end else begin
         rsp_key_in   = '0;
         rsp_count_in = '0;
         rsp_sum_in   = '0;
         rsp_max_in   = '0;
         rsp_min_in   = '1;
      end
   end

   // ---------------- fsm ----------------
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      fire          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               fire         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         enabled_ff   <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         enabled_ff   <= enabled_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_in;
         alloc_ff    <= alloc_in;
         once_ff     <= once_in;
         read_ok_ff  <= read_ok_in;
         slot_ff     <= slot_in;
         req_slot_ff <= req_slot_in;
         key_ff      <= key_in;
         iv_ff       <= iv_in;
      end
      if (accept && alloc_in) begin
         keys_ff[SLOT_BITS'(used_ff)] <= key_in;
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_svalid_ff <= rsp_svalid_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_sum_ff    <= rsp_sum_in;
         rsp_min_ff    <= rsp_min_in;
         rsp_max_ff    <= rsp_max_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.slot_index   = rsp_index_ff;
   assign rsp_bus.slot_valid   = rsp_svalid_ff;
   assign rsp_bus.slot_key     = rsp_key_ff;
   assign rsp_bus.sample_count = rsp_count_ff;
   assign rsp_bus.sum_us       = rsp_sum_ff;
   assign rsp_bus.min_us       = rsp_min_ff;
   assign rsp_bus.max_us       = rsp_max_ff;
   assign rsp_bus.slots_used   = rsp_used_ff;
endmodule

// ===== rtl/lst_ram.sv =====
// ----------------------------------------------------------------------------
// lst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/lst_checker.sv =====
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks of the latency statistics table, bound to the top level.
// ----------------------------------------------------------------------------
module lst_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [lst_pkg::STATUS_W-1:0]          rsp_status,
   input logic                                  rsp_slot_valid,
   input logic [lst_pkg::COUNT_BITS-1:0]        rsp_sample_count,
   input logic signed [lst_pkg::MINF_W-1:0]     rsp_min_us,
   input logic [lst_pkg::USEDF_W-1:0]           rsp_slots_used
);
   import lst_pkg::*;

   // a stalled response keeps its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   // an accepted request is followed by the update state, with the request side not ready
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during update cycle");

   // a fresh response only comes out of an update cycle
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without update cycle");

   // dropped and disabled records show an empty slot
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_DISABLED)
      |-> !rsp_slot_valid && rsp_sample_count == '0 && rsp_min_us == -1)
      else $error("dropped request shows slot contents");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slots_used <= USEDF_W'(SLOTS))
      else $error("slot count beyond table size");
endmodule

bind latency_statistics_table_top lst_checker u_lst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_slot_valid   (rsp_bus.slot_valid),
   .rsp_sample_count (rsp_bus.sample_count),
   .rsp_min_us       (rsp_bus.min_us),
   .rsp_slots_used   (rsp_bus.slots_used)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the latency statistics table. A clocked driver
// feeds requests from a queue, a clocked monitor checks every response
// against a local model of the slot table, and the register port is
// rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import lst_pkg::*;

   localparam logic [KIND_W-1:0]     KIND_READ     = 2'd2;
   localparam logic [KIND_W-1:0]     KIND_READ_ALT = 2'd3;
   localparam logic [STAMP_BITS-1:0] STAMP_MAX     = '1;
   localparam logic [EXT_BITS-1:0]   EXT_MAX       = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
   localparam logic signed [MINF_W-1:0] MIN_EMPTY  = -33'sd1;
   localparam int KEY_POOL   = 48;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 400;
   localparam int STALL_MAX  = 3000;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [KEYF_W-1:0]     key;
      logic [STAMP_BITS-1:0] start_us;
      logic [STAMP_BITS-1:0] now_us;
      logic [SLOTF_W-1:0]    slot;
   } lat_req_type;

   typedef struct packed {
      status_type               status;
      logic [SLOTF_W-1:0]       slot_index;
      logic                     slot_valid;
      logic [KEYF_W-1:0]        slot_key;
      logic [COUNT_BITS-1:0]    count;
      logic [STAMP_BITS-1:0]    sum;
      logic signed [MINF_W-1:0] min;
      logic [EXT_BITS-1:0]      max;
      logic [USEDF_W-1:0]       used;
   } slot_stats_type;

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   lst_req_if req_if ();
   lst_rsp_if rsp_if ();

   latency_statistics_table_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model of the slot table and its registers
   logic [KEY_BITS-1:0]   tbl_key   [SLOTS];
   logic [COUNT_BITS-1:0] tbl_count [SLOTS];
   logic [STAMP_BITS-1:0] tbl_sum   [SLOTS];
   logic [EXT_BITS-1:0]   tbl_min   [SLOTS];
   logic [EXT_BITS-1:0]   tbl_max   [SLOTS];
   int unsigned           tbl_used = 0;
   logic                  cfg_enabled = 1'b0;
   logic [STAMP_BITS-1:0] cfg_base = '0;

   lat_req_type    request_q [$];
   slot_stats_type stats_expect_q [$];
   lat_req_type    cur_req;
   int          requests_open = 0;
   int          errors = 0;
   int          responses_seen = 0;
   bit          no_idle = 1'b0;
   logic [KEYF_W-1:0] key_pool [KEY_POOL];

   function automatic slot_stats_type tally_request(lat_req_type it);
      slot_stats_type        r;
      int                    hit;
      logic [STAMP_BITS-1:0] from;
      logic [STAMP_BITS-1:0] span;
      logic [EXT_BITS-1:0]   span32;
      r.status     = ST_READ;
      r.slot_index = '0;
      r.slot_valid = 1'b0;
      r.slot_key   = '0;
      r.count      = '0;
      r.sum        = '0;
      r.min        = MIN_EMPTY;
      r.max        = '0;
      hit = -1;
      if (it.kind == KIND_READ || it.kind == KIND_READ_ALT) begin
         r.slot_index = it.slot;
         if (it.slot < tbl_used) hit = it.slot;
      end else if (!cfg_enabled) begin
         r.status = ST_DISABLED;
      end else begin
         for (int i = 0; i < tbl_used; i++)
            if (hit < 0 && tbl_key[i] == it.key[KEY_BITS-1:0]) hit = i;
         // unknown key takes the next free slot with empty statistics
         if (hit < 0 && tbl_used < SLOTS) begin
            hit = tbl_used;
            tbl_key[hit]   = it.key[KEY_BITS-1:0];
            tbl_count[hit] = '0;
            tbl_sum[hit]   = '0;
            tbl_min[hit]   = '0;
            tbl_max[hit]   = '0;
            tbl_used++;
         end
         if (hit < 0) begin
            r.status = ST_FULL;
         end else if (it.kind == KIND_ONCE && tbl_count[hit] != 0) begin
            r.status = ST_SKIPPED;
         end else begin
            from   = (it.kind == KIND_ONCE) ? cfg_base : it.start_us;
            span   = (it.now_us > from) ? it.now_us - from : '0;
            span32 = (span > {16'b0, EXT_MAX}) ? EXT_MAX : span[EXT_BITS-1:0];
            if (tbl_count[hit] == 0 || span32 < tbl_min[hit]) tbl_min[hit] = span32;
            if (span32 > tbl_max[hit]) tbl_max[hit] = span32;
            if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
            tbl_sum[hit] = (STAMP_MAX - tbl_sum[hit] < span) ? STAMP_MAX : tbl_sum[hit] + span;
            r.status = ST_RECORDED;
         end
         if (hit >= 0) r.slot_index = SLOTF_W'(hit);
      end
      if (hit >= 0) begin
         r.slot_valid = 1'b1;
         r.slot_key   = tbl_key[hit];
         r.count      = tbl_count[hit];
         r.sum        = tbl_sum[hit];
         r.min        = (tbl_count[hit] != 0) ? {1'b0, tbl_min[hit]} : MIN_EMPTY;
         r.max        = tbl_max[hit];
      end
      r.used = USEDF_W'(tbl_used);
      return r;
   endfunction

   function automatic logic [STAMP_BITS-1:0] rand_stamp();
      return STAMP_BITS'({$urandom, $urandom});
   endfunction

   function automatic lat_req_type make_request(int unsigned key_span);
      lat_req_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      it.kind = KIND_SINCE;
      else if (pick < 65) it.kind = KIND_ONCE;
      else if (pick < 92) it.kind = KIND_READ;
      else                it.kind = KIND_READ_ALT;
      it.key = ($urandom_range(0, 9) == 0) ? KEYF_W'($urandom)
                                           : key_pool[$urandom_range(0, key_span - 1)];
      it.slot     = SLOTF_W'($urandom);
      it.start_us = rand_stamp();
      if (it.kind == KIND_ONCE && $urandom_range(0, 2) != 0) begin
         it.now_us = cfg_base + STAMP_BITS'($urandom_range(0, 5000));
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.now_us = it.start_us + STAMP_BITS'($urandom_range(0, 2000));
            5:             it.now_us = it.start_us - STAMP_BITS'($urandom_range(0, 2000));
            6:             it.now_us = it.start_us + STAMP_BITS'($urandom);
            7:             it.now_us = rand_stamp();
            8:             it.now_us = it.start_us + (rand_stamp() >> $urandom_range(0, 16));
            default:       it.now_us = cfg_base + STAMP_BITS'($urandom_range(0, 5000));
         endcase
      end
      return it;
   endfunction

   task automatic queue_request(logic [KIND_W-1:0] kind, logic [KEYF_W-1:0] key,
                                logic [STAMP_BITS-1:0] start_us,
                                logic [STAMP_BITS-1:0] now_us, logic [SLOTF_W-1:0] slot);
      lat_req_type it;
      it.kind     = kind;
      it.key      = key;
      it.start_us = start_us;
      it.now_us   = now_us;
      it.slot     = slot;
      request_q.push_back(it);
      requests_open++;
   endtask

   task automatic wait_drained();
      while (requests_open != 0 || stats_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_IDX_ENABLED: cfg_enabled = value[0];
         CSR_IDX_BASE:    cfg_base    = value[STAMP_BITS-1:0];
      endcase
   endtask

   task automatic run_phase(logic en, logic [STAMP_BITS-1:0] base, int unsigned key_span,
                            int count, bit quiet);
      wait_drained();
      csr_write(CSR_IDX_ENABLED, {63'b0, en});
      csr_write(CSR_IDX_BASE, {16'b0, base});
      no_idle = quiet;
      for (int n = 0; n < count; n++) begin
         request_q.push_back(make_request(key_span));
         requests_open++;
      end
   endtask

   // request driver
   int   src_gap = 0;
   logic src_give;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            stats_expect_q.push_back(tally_request(cur_req));
            requests_open--;
         end
         if (!req_if.valid || req_if.ready) begin
            src_give = 1'b0;
            if (src_gap != 0) begin
               src_gap--;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
               src_gap = $urandom_range(0, 17);
            end else if (request_q.size() != 0) begin
               cur_req = request_q.pop_front();
               src_give = 1'b1;
               req_if.kind     <= cur_req.kind;
               req_if.key      <= cur_req.key;
               req_if.start_us <= cur_req.start_us;
               req_if.now_us   <= cur_req.now_us;
               req_if.slot     <= cur_req.slot;
            end
            req_if.valid <= src_give;
         end
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // response monitor
   slot_stats_type want;
   int          snk_gap = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   logic        snk_ready;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (stats_expect_q.size() == 0) begin
               errors++;
               $display("%0t: response with no request pending, status %h", $time,
                        rsp_if.status);
            end else begin
               want = stats_expect_q.pop_front();
               check_field("status", want.status, rsp_if.status);
               check_field("slot_index", want.slot_index, rsp_if.slot_index);
               check_field("slot_valid", want.slot_valid, rsp_if.slot_valid);
               check_field("slot_key", want.slot_key, rsp_if.slot_key);
               check_field("sample_count", want.count, rsp_if.sample_count);
               check_field("sum_us", want.sum, rsp_if.sum_us);
               check_field("min_us", want.min, rsp_if.min_us);
               check_field("max_us", want.max, rsp_if.max_us);
               check_field("slots_used", want.used, rsp_if.slots_used);
            end
         end
         // one long hold-off so the table backs up into the request side
         if (hold_left != 0) begin
            hold_left--;
            snk_ready = 1'b0;
         end else if (!hold_done && responses_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            snk_ready = 1'b0;
         end else if (snk_gap != 0) begin
            snk_gap--;
            snk_ready = 1'b0;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            snk_gap = $urandom_range(0, 17);
            snk_ready = 1'b0;
         end else begin
            snk_ready = 1'b1;
         end
         rsp_if.ready <= snk_ready;
      end
   end

   // watchdog on cycles without any transfer
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_MAX) begin
         $display("FAILURE");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   logic [KEYF_W-1:0] cand;
   bit                dup;
   initial begin
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_if.valid    = 1'b0;
      req_if.kind     = '0;
      req_if.key      = '0;
      req_if.start_us = '0;
      req_if.now_us   = '0;
      req_if.slot     = '0;
      rsp_if.ready    = 1'b0;

      for (int k = 0; k < KEY_POOL; k++) begin
         do begin
            cand = KEYF_W'($urandom);
            dup  = 1'b0;
            for (int j = 0; j < k; j++) if (key_pool[j] == cand) dup = 1'b1;
         end while (dup);
         key_pool[k] = cand;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: reads of free slots, records ignored
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd0);
      queue_request(KIND_READ_ALT, 16'hFFFF, STAMP_MAX, STAMP_MAX, 5'd31);
      queue_request(KIND_SINCE, 16'hFFFF, '0, 48'd100, 5'd0);
      queue_request(KIND_ONCE, 16'h0000, '0, STAMP_MAX, 5'd31);
      wait_drained();
      csr_write(CSR_IDX_ENABLED, 64'd1);
      csr_write(CSR_IDX_BASE, 64'd0);

      // zero interval, negative interval, saturation of sum and of min/max
      queue_request(KIND_SINCE, 16'h0000, '0, '0, 5'd0);
      queue_request(KIND_SINCE, 16'h0000, STAMP_MAX, '0, 5'd0);
      queue_request(KIND_SINCE, 16'hFFFF, '0, STAMP_MAX, 5'd0);
      queue_request(KIND_SINCE, 16'hFFFF, '0, STAMP_MAX, 5'd0);
      queue_request(KIND_SINCE, 16'h8001, 48'd5, 48'd5 + {16'b0, EXT_MAX}, 5'd0);
      queue_request(KIND_SINCE, 16'h8001, '0, 48'h1_0000_0000, 5'd0);
      // once-from-base: first records, repeats are skipped
      queue_request(KIND_ONCE, 16'h1234, '0, 48'd100, 5'd0);
      queue_request(KIND_ONCE, 16'h1234, '0, 48'd500, 5'd0);
      queue_request(KIND_ONCE, 16'h0000, '0, 48'd7, 5'd0);
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd0);
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd1);
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd3);
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd4);
      wait_drained();
      csr_write(CSR_IDX_BASE, {16'b0, STAMP_MAX});
      // stamp below base clamps to zero
      queue_request(KIND_ONCE, 16'h00AA, '0, 48'd5, 5'd0);
      queue_request(KIND_ONCE, 16'h5555, '0, STAMP_MAX, 5'd0);
      queue_request(KIND_READ_ALT, 16'h0000, '0, '0, 5'd5);
      wait_drained();
      csr_write(CSR_IDX_ENABLED, 64'd0);
      // reads still served while disabled
      queue_request(KIND_READ, 16'h0000, '0, '0, 5'd2);
      queue_request(KIND_SINCE, 16'h0000, '0, 48'd9, 5'd0);

      run_phase(1'b1, rand_stamp(), 6, 150, 1'b0);
      run_phase(1'b0, rand_stamp(), 12, 60, 1'b0);
      run_phase(1'b1, '0, 20, 200, 1'b0);
      run_phase(1'b1, STAMP_MAX, 30, 150, 1'b0);
      // key span beyond the slot count fills the table
      run_phase(1'b1, rand_stamp(), KEY_POOL, 440, 1'b0);
      run_phase(1'b1, STAMP_BITS'($urandom_range(0, 100000)), KEY_POOL, 150, 1'b1);

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && stats_expect_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
